// ===== src/clsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsr_pkg: shared constants and types for the combined LCG shuffle generator
// Holds both generators' multipliers and moduli, field widths and the request
// type of the shared modular multiply unit.
// ----------------------------------------------------------------------------
package clsr_pkg;

  // Default sizes
  localparam int DEF_TABLE_DEPTH  = 32;
  localparam int DEF_WARMUP_STEPS = 40;

  // Field widths
  localparam int VAL_W  = 31;
  localparam int FRAC_W = 24;
  localparam int MUL_W  = 16;
  localparam int OFF_W  = 8;

  // First generator: modulus is 2^31 - 85
  localparam logic [MUL_W-1:0] MUL_A     = 16'd40014;
  localparam logic [31:0]      MOD_A     = 32'd2147483563;
  localparam logic [OFF_W-1:0] MOD_A_OFF = 8'd85;

  // Second generator: modulus is 2^31 - 249
  localparam logic [MUL_W-1:0] MUL_B     = 16'd40692;
  localparam logic [31:0]      MOD_B     = 32'd2147483399;
  localparam logic [OFF_W-1:0] MOD_B_OFF = 8'd249;

  // Combined value range and fraction clamp
  localparam logic [VAL_W-1:0]  COMB_MAX = 31'd2147483562;
  localparam logic [FRAC_W-1:0] FRAC_MAX = 24'd16777214;

  // Reset values
  localparam logic [VAL_W-1:0] SEED_RST   = 31'd1;
  localparam logic [VAL_W-1:0] FIRST_RST  = 31'd1;
  localparam logic [VAL_W-1:0] SECOND_RST = 31'd123456789;

  // Generator select for the multiply unit
  typedef enum logic {
    GEN_A = 1'b0,
    GEN_B = 1'b1
  } gen_sel_t;

  // Request into the multiply unit
  typedef struct packed {
    logic     valid;
    gen_sel_t sel;
  } mm_req_t;

endpackage

// ===== src/combined_lcg_shuffle_rng_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng_top: combined LCG generator with shuffle table
// Two multiplicative congruential generators share one pipelined modular
// multiplier; a table memory shuffles the first generator's values.
//
//   channel  | dir | ports                           | content
//   ---------+-----+---------------------------------+--------------------------
//   request  | in  | in_tvalid/in_tready/in_tdata    | restart flag
//   result   | out | out_tvalid/out_tready/out_tdata | value, fraction
//   config   | in  | cfg_wr_en/cfg_wr_data           | seed value
//
// A draw issues its first generator step on accept and then runs D1, D2, D3:
// the two generator steps run back to back through the two-stage multiply
// unit and the table read lands in time for the combine. A reseeding request
// (restart, or the first after reset) first passes SLOAD, then SWAIT and SWB
// per warm-up step to wait on the multiply unit. Reset needs no clearing pass.
// The output register holds a result while the next draw runs; a draw waits
// at its combine step only while both the fraction stage and the output
// register still hold older results.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng_top #(
  parameter int TABLE_DEPTH  = clsr_pkg::DEF_TABLE_DEPTH,
  parameter int WARMUP_STEPS = clsr_pkg::DEF_WARMUP_STEPS
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [0] restart, [7:1] zero
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,    // [30:0] value, [54:31] fraction, [55] zero
  // configuration
  input  logic        cfg_wr_en,
  input  logic [30:0] cfg_wr_data
);

  localparam int VW    = clsr_pkg::VAL_W;
  localparam int FW    = clsr_pkg::FRAC_W;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(WARMUP_STEPS);

  // Index divisor and its reciprocal for exact division of 31-bit values
  localparam longint DIVISOR = 1 + longint'(clsr_pkg::COMB_MAX) / TABLE_DEPTH;
  localparam int     DIV_L   = $clog2(DIVISOR);
  localparam int     SH      = VW + DIV_L;
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam int     IP_W    = VW + 32;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SLOAD = 7'b0000010,
    ST_SWAIT = 7'b0000100,
    ST_SWB   = 7'b0001000,
    ST_D1    = 7'b0010000,
    ST_D2    = 7'b0100000,
    ST_D3    = 7'b1000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [VW-1:0]        seed_r;
  logic [VW-1:0]        first_r, second_r, last_r;
  logic                 seeded_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [VW-1:0]        rd_r;
  logic [IP_W-1:0]      idx_prod_r;
  logic                 go_r;
  logic                 f1_valid_r;
  logic [VW-1:0]        f1_val_r;
  logic [FW-1:0]        f1_q_r;
  logic [31:0]          f1_rem_r;
  logic                 out_valid_r;
  logic [VW-1:0]        out_value_r;
  logic [FW-1:0]        out_frac_r;

  logic [VW-1:0]        shuf_mem [TABLE_DEPTH];

  logic                 accept;
  logic                 need_seed;
  logic [VW-1:0]        seed_eff;
  logic [VW-1:0]        mm_res;
  clsr_pkg::mm_req_t    mm_req;
  logic [VW-1:0]        mm_opnd;
  logic [IP_W-1:0]      idx_q;
  logic [IDX_W-1:0]     idx;
  logic                 cnt_in_tbl;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [VW-1:0]        mem_wdata;
  logic signed [32:0]   diff;
  logic signed [32:0]   diff_adj;
  logic [VW-1:0]        comb;
  logic                 out_free;
  logic                 f1_move;
  logic                 d3_go;
  logic [1:0]           frac_corr;
  logic [FW:0]          frac_sum;
  logic [FW-1:0]        frac;

  assign accept    = in_tvalid && in_tready;
  assign need_seed = in_tdata[0] || !seeded_r;
  assign seed_eff  = (seed_r == '0) ? VW'(1) : seed_r;

  // Shared modular multiply unit
  clsr_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mm_req),
    .operand (mm_opnd),
    .result  (mm_res)
  );

  // Table index from the previous combined value: reciprocal multiply, saturate
  always_ff @(posedge clk) begin
    idx_prod_r <= IP_W'(last_r) * IP_W'(RECIP[31:0]);
  end
  assign idx_q = idx_prod_r >> SH;
  assign idx   = (idx_q >= IP_W'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH - 1)
                                                : idx_q[IDX_W-1:0];

  // Combine the shuffled entry with the second generator
  assign diff     = $signed({2'b00, rd_r}) - $signed({2'b00, mm_res});
  assign diff_adj = (diff < 33'sd1) ? diff + $signed({2'b00, clsr_pkg::COMB_MAX}) : diff;
  assign comb     = diff_adj[VW-1:0];

  assign out_free = !out_valid_r || out_tready;
  assign f1_move  = f1_valid_r && out_free;
  assign d3_go    = (state_r == ST_D3) && (!f1_valid_r || out_free);

  assign cnt_in_tbl = 32'(cnt_r) < 32'(TABLE_DEPTH);

  // Multiply requests: first generator on accept, seeding and warm-up, second in D1
  always_comb begin
    mm_req.valid = 1'b0;
    mm_req.sel   = clsr_pkg::GEN_A;
    mm_opnd      = first_r;
    unique case (state_r)
      ST_IDLE: begin
        mm_req.valid = accept && !need_seed;
      end
      ST_SLOAD: begin
        mm_req.valid = 1'b1;
        mm_opnd      = seed_eff;
      end
      ST_SWB: begin
        mm_req.valid = 1'b1;
        mm_opnd      = mm_res;
      end
      ST_D1: begin
        mm_req.valid = 1'b1;
        mm_req.sel   = clsr_pkg::GEN_B;
        mm_opnd      = second_r;
      end
      default: begin
        mm_req.valid = 1'b0;
      end
    endcase
  end

  // Table write port: warm-up fill or draw replacement
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = first_r;
    if (state_r == ST_SWB) begin
      mem_we    = cnt_in_tbl;
      mem_waddr = IDX_W'(cnt_r);
      mem_wdata = mm_res;
    end else if (d3_go) begin
      mem_we = 1'b1;
    end
  end

  // Shuffle table memory; reads issue in D2, writes only in warm-up and D3
  always_ff @(posedge clk) begin
    if (mem_we) begin
      shuf_mem[mem_waddr] <= mem_wdata;
    end
    if (state_r == ST_D2) begin
      rd_r <= shuf_mem[idx];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = need_seed ? ST_SLOAD : ST_D1;
      ST_SLOAD: state_nxt = ST_SWAIT;
      ST_SWAIT: state_nxt = ST_SWB;
      ST_SWB:   state_nxt = (cnt_r == '0) ? ST_D1 : ST_SWAIT;
      ST_D1:    state_nxt = ST_D2;
      ST_D2:    state_nxt = ST_D3;
      ST_D3:    if (d3_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);

  // Control state and generator registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      seed_r   <= clsr_pkg::SEED_RST;
      first_r  <= clsr_pkg::FIRST_RST;
      second_r <= clsr_pkg::SECOND_RST;
      last_r   <= '0;
      seeded_r <= 1'b0;
      cnt_r    <= '0;
      go_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= d3_go;
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      unique case (state_r)
        ST_SLOAD: begin
          first_r  <= seed_eff;
          second_r <= seed_eff;
          cnt_r    <= CNT_W'(WARMUP_STEPS - 1);
        end
        ST_SWB: begin
          first_r <= mm_res;
          last_r  <= mm_res;
          if (cnt_r == '0) begin
            seeded_r <= 1'b1;
          end else begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        ST_D2: begin
          first_r <= mm_res;
        end
        ST_D3: begin
          if (d3_go) begin
            second_r <= mm_res;
            last_r   <= comb;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Fraction, first step: quotient estimate c >> 7 and its remainder
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (go_r) begin
      f1_valid_r <= 1'b1;
    end else if (f1_move) begin
      f1_valid_r <= 1'b0;
    end
    if (go_r) begin
      f1_val_r <= last_r;
      f1_q_r   <= last_r[VW-1:7];
      f1_rem_r <= 32'({last_r[6:0], 24'd0})
                + 32'(last_r[VW-1:7]) * 32'(clsr_pkg::MOD_A_OFF);
    end
  end

  // Fraction, second step: correct by up to two and clamp below one
  always_comb begin
    if (33'(f1_rem_r) >= (33'(clsr_pkg::MOD_A) << 1)) begin
      frac_corr = 2'd2;
    end else if (f1_rem_r >= clsr_pkg::MOD_A) begin
      frac_corr = 2'd1;
    end else begin
      frac_corr = 2'd0;
    end
    frac_sum = (FW + 1)'(f1_q_r) + (FW + 1)'(frac_corr);
    frac     = (frac_sum > (FW + 1)'(clsr_pkg::FRAC_MAX)) ? clsr_pkg::FRAC_MAX
                                                         : frac_sum[FW-1:0];
  end

  // Output register: load on a free slot, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (f1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (f1_move) begin
      out_value_r <= f1_val_r;
      out_frac_r  <= frac;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_frac_r, out_value_r};

`ifndef SYNTHESIS
  // A fraction job never lands on a held first step
  a_f1_free: assert property (@(posedge clk) disable iff (!rst_n)
    go_r |-> !f1_valid_r)
    else $error("fraction stage overwritten");

  // Once seeded, the generator stays seeded
  a_seeded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    seeded_r |=> seeded_r)
    else $error("seeded flag dropped");

  // Delivered value lies in the combined range
  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_value_r != '0) && (out_value_r <= clsr_pkg::COMB_MAX))
    else $error("combined value out of range");

  // A draw only reaches the combine step after the unit returned both steps
  a_d3_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_D3) && !$past(state_r == ST_D3) |-> $past(state_r == ST_D2, 1)
      && $past(state_r == ST_D1, 2))
    else $error("combine step out of order");
`endif

endmodule

// ===== src/clsr_mulmod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsr_mulmod: two-stage constant modular multiply
// Stage one forms the multiplier times the operand; stage two folds the high
// part back using 2^31 = offset (mod modulus) and finishes with one subtract.
// ----------------------------------------------------------------------------
module clsr_mulmod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  clsr_pkg::mm_req_t           req,
  input  logic [clsr_pkg::VAL_W-1:0]  operand,
  output logic [clsr_pkg::VAL_W-1:0]  result
);

  localparam int PROD_W = clsr_pkg::MUL_W + clsr_pkg::VAL_W;

  logic [PROD_W-1:0]              prod_r;
  clsr_pkg::gen_sel_t             sel1_r;
  logic                           v1_r;
  logic [clsr_pkg::VAL_W-1:0]     res_r;

  logic [clsr_pkg::MUL_W-1:0]     mul_sel;
  logic [clsr_pkg::OFF_W-1:0]     off_sel;
  logic [31:0]                    mod_sel;
  logic [31:0]                    fold;

  // Pick the multiplier of the requested generator
  always_comb begin
    case (req.sel)
      clsr_pkg::GEN_A: mul_sel = clsr_pkg::MUL_A;
      default:         mul_sel = clsr_pkg::MUL_B;
    endcase
  end

  // Pick fold offset and modulus for the product in stage two
  always_comb begin
    case (sel1_r)
      clsr_pkg::GEN_A: begin
        off_sel = clsr_pkg::MOD_A_OFF;
        mod_sel = clsr_pkg::MOD_A;
      end
      default: begin
        off_sel = clsr_pkg::MOD_B_OFF;
        mod_sel = clsr_pkg::MOD_B;
      end
    endcase
  end

  // Fold: low 31 bits plus high part times offset, always below twice the modulus
  assign fold = 32'(prod_r[clsr_pkg::VAL_W-1:0])
              + 32'(prod_r[PROD_W-1:clsr_pkg::VAL_W]) * 32'(off_sel);

  // Stage one: product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= req.valid;
    end
    if (req.valid) begin
      prod_r <= PROD_W'(mul_sel) * PROD_W'(operand);
      sel1_r <= req.sel;
    end
  end

  // Stage two: reduce and hold until the next request arrives
  always_ff @(posedge clk) begin
    if (v1_r) begin
      if (fold >= mod_sel) begin
        res_r <= clsr_pkg::VAL_W'(fold - mod_sel);
      end else begin
        res_r <= clsr_pkg::VAL_W'(fold);
      end
    end
  end

  assign result = res_r;

endmodule
